@@ rtl/fas_pkg.sv @@
// Shared types, fixed-point constants and the arctangent table of the firing angle solver.
`default_nettype none
package fas_pkg;

  localparam int AW = 32;   // angle, sine, cosine and coefficient width (signed Q.24)
  localparam int FW = 34;   // residual and slope width (signed Q.24)
  localparam int NW = 60;   // divider dividend width
  localparam int DW = 28;   // divider divisor width
  localparam int QW = 29;   // divider quotient width

  localparam logic signed [AW-1:0] ONE_Q     = 32'sd16777216;
  localparam logic signed [AW-1:0] PI_Q      = 32'sd52707179;
  localparam logic signed [AW-1:0] TWO_PI_Q  = 32'sd105414357;
  localparam logic signed [AW-1:0] HALF_PI_Q = 32'sd26353589;
  localparam logic signed [AW-1:0] GAIN_Q    = 32'sd10188014;
  localparam logic signed [AW-1:0] X_LIMIT   = 32'sd134217728;
  localparam logic signed [AW-1:0] K0_Q      = 32'sd127003955;

  localparam logic [26:0] TWO_PI_U    = 27'd105414357;
  localparam logic [25:0] PI_U        = 26'd52707179;
  localparam logic [25:0] PI_HALF_RND = 26'd26353589;
  localparam logic [14:0] ANGLE_MAX   = 15'd25736;

  // Compare scaling: 2^26 / pi, that is 1 / (8192 * pi) in Q.39, so the estimate is within one of the quotient.
  localparam int          CMP_SHIFT = 39;
  localparam logic [24:0] CMP_RECIP = 25'd21361414;
  localparam logic [56:0] CMP_ROUND = 57'd1 << (CMP_SHIFT - 1);

  localparam logic [15:0] PERIOD_RST = 16'd58100;
  localparam logic [7:0]  TOL_RST    = 8'd8;
  localparam logic [15:0] RATIO_ONE  = 16'd32768;

  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_TOL    = 1'b1;

  typedef struct packed {
    logic load;
    logic coef;
    logic eval_go;
    logic ndiv_go;
    logic update;
    logic angle_go;
    logic zero_angle;
    logic cest;
    logic cfix;
    logic publish;
    logic conv;
  } fas_cmd_t;

  typedef struct packed {
    logic ratio_one;
    logic eval_done;
    logic div_done;
    logic d_zero;
    logic f_small;
    logic out_busy;
  } fas_stat_t;

  function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0:    v = 32'sd13176795;
      5'd1:    v = 32'sd7778716;
      5'd2:    v = 32'sd4110060;
      5'd3:    v = 32'sd2086331;
      5'd4:    v = 32'sd1047214;
      5'd5:    v = 32'sd524117;
      5'd6:    v = 32'sd262123;
      5'd7:    v = 32'sd131069;
      5'd8:    v = 32'sd65536;
      5'd9:    v = 32'sd32768;
      5'd10:   v = 32'sd16384;
      5'd11:   v = 32'sd8192;
      5'd12:   v = 32'sd4096;
      5'd13:   v = 32'sd2048;
      5'd14:   v = 32'sd1024;
      5'd15:   v = 32'sd512;
      5'd16:   v = 32'sd256;
      5'd17:   v = 32'sd128;
      5'd18:   v = 32'sd64;
      5'd19:   v = 32'sd32;
      5'd20:   v = 32'sd16;
      5'd21:   v = 32'sd8;
      5'd22:   v = 32'sd4;
      5'd23:   v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fas_cordic.sv @@
// Iterative rotation-mode CORDIC with range reduction, giving sine and cosine in Q.24.
`default_nettype none
module fas_cordic #(
  parameter int STAGES = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire  logic signed [fas_pkg::AW-1:0] theta,
  output logic                               done,
  output logic signed [fas_pkg::AW-1:0]      sin_val,
  output logic signed [fas_pkg::AW-1:0]      cos_val
);

  localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RED  = 3'b010,
    C_ROT  = 3'b100
  } cphase_t;

  cphase_t                       phase;
  logic signed [fas_pkg::AW-1:0] t;
  logic signed [fas_pkg::AW-1:0] cx;
  logic signed [fas_pkg::AW-1:0] cy;
  logic signed [fas_pkg::AW-1:0] z;
  logic                          neg_cos;
  logic [IW-1:0]                 idx;

  logic signed [fas_pkg::AW-1:0] t_wrap;
  logic signed [fas_pkg::AW-1:0] z_init;
  logic                          neg_init;
  logic signed [fas_pkg::AW-1:0] dx;
  logic signed [fas_pkg::AW-1:0] dy;
  logic signed [fas_pkg::AW-1:0] atan_v;

  // Fold the reduced angle into [-pi/2, pi/2]; the cosine sign is fixed up at the end.
  always_comb begin
    if (t > fas_pkg::PI_Q) begin
      t_wrap = t - fas_pkg::TWO_PI_Q;
    end else if (t < -fas_pkg::PI_Q) begin
      t_wrap = t + fas_pkg::TWO_PI_Q;
    end else begin
      t_wrap = t;
    end
    if (t_wrap > fas_pkg::HALF_PI_Q) begin
      z_init   = fas_pkg::PI_Q - t_wrap;
      neg_init = 1'b1;
    end else if (t_wrap < -fas_pkg::HALF_PI_Q) begin
      z_init   = -fas_pkg::PI_Q - t_wrap;
      neg_init = 1'b1;
    end else begin
      z_init   = t_wrap;
      neg_init = 1'b0;
    end
  end

  assign dx     = cy >>> idx;
  assign dy     = cx >>> idx;
  assign atan_v = fas_pkg::atan_entry(5'(idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        C_IDLE: begin
          if (start) begin
            t     <= theta;
            phase <= C_RED;
          end
        end
        C_RED: begin
          // Remainder keeps the sign of the angle, as a truncating modulo does.
          if (!t[fas_pkg::AW-1] && t >= fas_pkg::TWO_PI_Q) begin
            t <= t - fas_pkg::TWO_PI_Q;
          end else if (t[fas_pkg::AW-1] && t <= -fas_pkg::TWO_PI_Q) begin
            t <= t + fas_pkg::TWO_PI_Q;
          end else begin
            z       <= z_init;
            neg_cos <= neg_init;
            cx      <= fas_pkg::GAIN_Q;
            cy      <= '0;
            idx     <= '0;
            phase   <= C_ROT;
          end
        end
        C_ROT: begin
          if (!z[fas_pkg::AW-1]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            z  <= z - atan_v;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            z  <= z + atan_v;
          end
          idx <= idx + 1'b1;
          if (idx == IW'(STAGES - 1)) begin
            done  <= 1'b1;
            phase <= C_IDLE;
          end
        end
        default: phase <= C_IDLE;
      endcase
    end
  end

  assign sin_val = cy;
  assign cos_val = neg_cos ? -cx : cx;

endmodule
`default_nettype wire

@@ rtl/fas_divider.sv @@
// Restoring divider, one quotient bit per cycle, with an overflow flag for large quotients.
`default_nettype none
module fas_divider (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  wire  [fas_pkg::NW-1:0]    num,
  input  wire  [fas_pkg::DW-1:0]    den,
  output logic                      done,
  output logic [fas_pkg::QW-1:0]    quo,
  output logic                      ovf
);

  localparam int CW = $clog2(fas_pkg::QW);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [fas_pkg::NW-1:0] rem;
  logic [fas_pkg::NW-1:0] dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(fas_pkg::QW - 1);
        rem  <= num;
        dsh  <= fas_pkg::NW'({den, {(fas_pkg::QW-1){1'b0}}});
        quo  <= '0;
        // The quotient does not fit when the dividend reaches the divisor times 2^QW.
        ovf  <= num >= fas_pkg::NW'({den, {fas_pkg::QW{1'b0}}});
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[fas_pkg::QW-2:0], 1'b1};
        end else begin
          quo <= {quo[fas_pkg::QW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fas_datapath.sv @@
// Datapath: registers, coefficient multipliers, CORDIC, divider, compare scaling and output.
`default_nettype none
module fas_datapath #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire  fas_pkg::fas_cmd_t   cmd,
  output fas_pkg::fas_stat_t        stat,
  input  wire  [15:0]               power_ratio,
  input  wire                       cfg_we,
  input  wire                       cfg_index,
  input  wire  [15:0]               cfg_data,
  output logic [14:0]               trigger_angle,
  output logic [15:0]               compare_value,
  output logic                      converged,
  output logic                      out_of_range,
  output logic                      out_valid,
  input  wire                       out_ready
);

  logic [15:0] timer_period;
  logic [7:0]  residual_tolerance;

  logic [15:0] ratio;
  logic [31:0] sq;
  logic [58:0] prodc;
  logic [30:0] pa;

  logic signed [fas_pkg::AW-1:0] c;
  logic signed [fas_pkg::AW-1:0] x;
  logic signed [fas_pkg::FW-1:0] f;
  logic signed [fas_pkg::FW-1:0] d;
  logic                          neg;
  logic [14:0]                   angle;
  logic                          oor;

  logic signed [fas_pkg::AW-1:0] theta;
  logic                          cor_done;
  logic signed [fas_pkg::AW-1:0] sin_v;
  logic signed [fas_pkg::AW-1:0] cos_v;

  logic [fas_pkg::FW-1:0] fabs;
  logic [fas_pkg::FW-1:0] dabs;
  logic [fas_pkg::NW-1:0] div_num;
  logic [fas_pkg::DW-1:0] div_den;
  logic                   div_done;
  logic [fas_pkg::QW-1:0] quo;
  logic                   ovf;

  logic signed [fas_pkg::AW-1:0] qs;
  logic signed [fas_pkg::AW-1:0] xn;
  logic signed [fas_pkg::AW-1:0] xr;
  logic [16:0]                   a17;

  logic [56:0]        cmul;
  logic [16:0]        est;
  logic [43:0]        cnum;
  logic [43:0]        cqpi;
  logic signed [44:0] crem;
  logic [16:0]        cq;
  logic [15:0]        cmpv;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period       <= fas_pkg::PERIOD_RST;
      residual_tolerance <= fas_pkg::TOL_RST;
    end else if (cfg_we) begin
      if (cfg_index == fas_pkg::REG_PERIOD) begin
        timer_period <= cfg_data;
      end else begin
        residual_tolerance <= cfg_data[7:0];
      end
    end
  end

  assign theta = {x[fas_pkg::AW-2:0], 1'b0};

  fas_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.eval_go),
    .theta  (theta),
    .done   (cor_done),
    .sin_val(sin_v),
    .cos_val(cos_v)
  );

  assign fabs = f[fas_pkg::FW-1] ? fas_pkg::FW'(-f) : fas_pkg::FW'(f);
  assign dabs = d[fas_pkg::FW-1] ? fas_pkg::FW'(-d) : fas_pkg::FW'(d);

  assign div_num = fas_pkg::NW'({fabs, 24'b0});
  assign div_den = fas_pkg::DW'(dabs);

  fas_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.ndiv_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo),
    .ovf  (ovf)
  );

  // Newton update x - f/f', with the step saturating the angle at +-8 rad.
  always_comb begin
    qs  = fas_pkg::AW'(quo);
    xn  = neg ? x + qs : x - qs;
    xr  = x + 32'sd1024;
    a17 = xr[27:11];
  end

  // The reciprocal estimate is off by at most one; the remainder check settles it.
  always_comb begin
    cmul = 57'(pa) * 57'(fas_pkg::CMP_RECIP) + fas_pkg::CMP_ROUND;
    cnum = 44'({pa, 11'b0}) + 44'(fas_pkg::PI_HALF_RND);
    cqpi = 44'(est) * 44'(fas_pkg::PI_U);
    crem = $signed({1'b0, cnum}) - $signed({1'b0, cqpi});
    if (crem[44]) begin
      cq = est - 1'b1;
    end else if (crem >= $signed(45'(fas_pkg::PI_U))) begin
      cq = est + 1'b1;
    end else begin
      cq = est;
    end
  end

  always_ff @(posedge clk) begin
    sq    <= 32'(ratio) * 32'(ratio);
    prodc <= 59'(sq) * 59'(fas_pkg::TWO_PI_U);
    pa    <= 31'(angle) * 31'(timer_period);
    if (cmd.load) begin
      ratio <= power_ratio;
    end
    if (cmd.coef) begin
      c <= fas_pkg::K0_Q - $signed({3'b000, prodc[58:30]});
      x <= fas_pkg::HALF_PI_Q;
    end
    if (cor_done) begin
      f <= fas_pkg::FW'(sin_v) - fas_pkg::FW'(theta) + fas_pkg::FW'(c);
      d <= fas_pkg::FW'(cos_v) + fas_pkg::FW'(cos_v) - fas_pkg::FW'(fas_pkg::ONE_Q <<< 1);
    end
    if (cmd.ndiv_go) begin
      neg <= f[fas_pkg::FW-1] ^ d[fas_pkg::FW-1];
    end
    if (cmd.update) begin
      if (ovf) begin
        x <= neg ? fas_pkg::X_LIMIT : -fas_pkg::X_LIMIT;
      end else if (xn > fas_pkg::X_LIMIT) begin
        x <= fas_pkg::X_LIMIT;
      end else if (xn < -fas_pkg::X_LIMIT) begin
        x <= -fas_pkg::X_LIMIT;
      end else begin
        x <= xn;
      end
    end
    if (cmd.angle_go) begin
      if (cmd.zero_angle) begin
        angle <= '0;
        oor   <= 1'b0;
      end else if (x[fas_pkg::AW-1]) begin
        angle <= '0;
        oor   <= 1'b1;
      end else if (a17 > 17'(fas_pkg::ANGLE_MAX)) begin
        angle <= fas_pkg::ANGLE_MAX;
        oor   <= 1'b1;
      end else begin
        angle <= a17[14:0];
        oor   <= 1'b0;
      end
    end
    if (cmd.cest) begin
      est <= cmul[fas_pkg::CMP_SHIFT +: 17];
    end
    if (cmd.cfix) begin
      cmpv <= cq[16] ? 16'hFFFF : cq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      trigger_angle <= angle;
      compare_value <= cmpv;
      converged     <= cmd.conv;
      out_of_range  <= oor;
    end
  end

  always_comb begin
    stat.ratio_one = ratio == fas_pkg::RATIO_ONE;
    stat.eval_done = cor_done;
    stat.div_done  = div_done;
    stat.d_zero    = d == '0;
    stat.f_small   = fabs < fas_pkg::FW'({residual_tolerance, 11'b0});
    stat.out_busy  = out_valid & ~out_ready;
  end

endmodule
`default_nettype wire

@@ rtl/fas_ctrl.sv @@
// Controller: sequences coefficient setup, Newton iterations, angle rounding and compare scaling.
`default_nettype none
module fas_ctrl #(
  parameter int MAX_ITERATIONS = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  output fas_pkg::fas_cmd_t         cmd,
  input  wire  fas_pkg::fas_stat_t  stat
);

  localparam int KW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_SQ     = 15'b000000000000010,
    S_MUL    = 15'b000000000000100,
    S_COEF   = 15'b000000000001000,
    S_EVAL   = 15'b000000000010000,
    S_EVAL_W = 15'b000000000100000,
    S_CHECK  = 15'b000000001000000,
    S_DIV    = 15'b000000010000000,
    S_DIV_W  = 15'b000000100000000,
    S_UPD    = 15'b000001000000000,
    S_ANGLE  = 15'b000010000000000,
    S_CMUL   = 15'b000100000000000,
    S_CEST   = 15'b001000000000000,
    S_CFIX   = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [KW-1:0] k;
  logic [KW-1:0] k_next;
  logic          first;
  logic          first_next;
  logic          conv;
  logic          conv_next;
  logic          zero;
  logic          zero_next;

  always_comb begin
    state_next = state;
    k_next     = k;
    first_next = first;
    conv_next  = conv;
    zero_next  = zero;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SQ;
          conv_next  = 1'b0;
          zero_next  = 1'b0;
        end
      end
      S_SQ: begin
        if (stat.ratio_one) begin
          conv_next  = 1'b1;
          zero_next  = 1'b1;
          state_next = S_ANGLE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL:    state_next = S_COEF;
      S_COEF: begin
        k_next     = '0;
        first_next = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL:   state_next = S_EVAL_W;
      S_EVAL_W: begin
        if (stat.eval_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // After an update the residual of the new angle closes the iteration.
        first_next = 1'b0;
        if (!first && stat.f_small) begin
          conv_next  = 1'b1;
          state_next = S_ANGLE;
        end else if (!first && k == KW'(MAX_ITERATIONS - 1)) begin
          state_next = S_ANGLE;
        end else if (stat.d_zero) begin
          state_next = S_ANGLE;
        end else begin
          if (!first) begin
            k_next = k + 1'b1;
          end
          state_next = S_DIV;
        end
      end
      S_DIV:    state_next = S_DIV_W;
      S_DIV_W: begin
        if (stat.div_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD:    state_next = S_EVAL;
      S_ANGLE:  state_next = S_CMUL;
      S_CMUL:   state_next = S_CEST;
      S_CEST:   state_next = S_CFIX;
      S_CFIX:   state_next = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      first <= 1'b1;
      conv  <= 1'b0;
      zero  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      first <= first_next;
      conv  <= conv_next;
      zero  <= zero_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.coef       = state == S_COEF;
    cmd.eval_go    = state == S_EVAL;
    cmd.ndiv_go    = state == S_DIV;
    cmd.update     = state == S_UPD;
    cmd.angle_go   = state == S_ANGLE;
    cmd.zero_angle = zero;
    cmd.cest       = state == S_CEST;
    cmd.cfix       = state == S_CFIX;
    cmd.publish    = (state == S_DONE) && !stat.out_busy;
    cmd.conv       = conv;
  end

`ifndef ASSERT_OFF
  a_upd_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $past(state == S_DIV_W))
    else $error("angle update without a finished division");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (k <= KW'(MAX_ITERATIONS - 1)))
    else $error("iteration count beyond its bound");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !stat.out_busy)
    else $error("result published over a waiting item");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SQ))
    else $error("accepted item did not start processing");
`endif

endmodule
`default_nettype wire

@@ rtl/firing_angle_solver.sv @@
// Top level of the firing angle solver: controller and datapath.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   power_ratio
//   out      output     out_valid / out_ready trigger_angle, compare_value, converged,
//                                             out_of_range
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// An item ends early when the residual meets the tolerance before MAX_ITERATIONS
// Newton steps have run, and a ratio of one skips the Newton steps altogether.
// Each Newton step is one CORDIC pass (range reduction, then one stage per cycle) and
// one 29-step restoring division; the compare value is built through the pa, est and
// cmpv registers.
// One item is in work at a time; in_ready is high only while the solver is idle.
// A finished result waits in the output register, and the next item is taken meanwhile.
// Reset is synchronous and restores timer_period to 58100 and residual_tolerance to 8.
`default_nettype none
module firing_angle_solver #(
  parameter int MAX_ITERATIONS = 16,
  parameter int CORDIC_STAGES  = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] power_ratio,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [14:0] trigger_angle,
  output logic [15:0] compare_value,
  output logic        converged,
  output logic        out_of_range,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_data
);

  fas_pkg::fas_cmd_t  cmd;
  fas_pkg::fas_stat_t stat;

  fas_ctrl #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  fas_datapath #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .power_ratio  (power_ratio),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .trigger_angle(trigger_angle),
    .compare_value(compare_value),
    .converged    (converged),
    .out_of_range (out_of_range),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule
`default_nettype wire
